>>> rtl/i2crbp_pkg.sv
// ----------------------------------------------------------------------------
// i2crbp_pkg
// Shared codes, reset values and types of the I2C register block poller.
// ----------------------------------------------------------------------------
package i2crbp_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int QDEPTH      = 2;

  localparam logic [2:0] ACT_START_SENT = 3'd0;
  localparam logic [2:0] ACT_TX_MODE    = 3'd1;
  localparam logic [2:0] ACT_BYTE_SENT  = 3'd2;
  localparam logic [2:0] ACT_RX_MODE    = 3'd3;
  localparam logic [2:0] ACT_BYTE_RCVD  = 3'd4;
  localparam logic [2:0] ACT_RELEASED   = 3'd5;

  localparam logic [2:0] CMD_ADDR_W  = 3'd0;
  localparam logic [2:0] CMD_ADDR_R  = 3'd1;
  localparam logic [2:0] CMD_REG     = 3'd2;
  localparam logic [2:0] CMD_START   = 3'd3;
  localparam logic [2:0] CMD_STOP    = 3'd4;
  localparam logic [2:0] CMD_ACK_OFF = 3'd5;
  localparam logic [2:0] CMD_ACK_ON  = 3'd6;
  localparam logic [2:0] CMD_STORE   = 3'd7;

  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_ENTRY_COUNT    = 2'd1;
  localparam logic [1:0] REG_REGISTER_TABLE = 2'd2;
  localparam logic [1:0] REG_LENGTH_TABLE   = 2'd3;

  localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd40;
  localparam logic [3:0]  ENTRY_COUNT_RST    = 4'd1;
  localparam logic [63:0] REGISTER_TABLE_RST = 64'h0;
  localparam logic [63:0] LENGTH_TABLE_RST   = 64'h0101010101010101;

  // One accepted event as a burst of up to three commands. Only the first
  // command carries a payload; the followers are implied by it.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] cmd_byte;
    logic [2:0] entry;
    logic [7:0] offset;
    logic       done;
    logic [1:0] n;
  } desc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

>>> rtl/i2crbp_if.sv
// ----------------------------------------------------------------------------
// i2crbp_if
// Valid/ready channels for bus events and sequencer commands.
// ----------------------------------------------------------------------------
interface i2crbp_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] rx_data;

  modport source (output valid, action, rx_data, input ready);
  modport sink (input valid, action, rx_data, output ready);
endinterface

interface i2crbp_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] command_byte;
  logic [2:0] entry_index;
  logic [7:0] byte_offset;
  logic       list_done;
  logic       last;

  modport source (output valid, command, command_byte, entry_index, byte_offset,
                  list_done, last, input ready);
  modport sink (input valid, command, command_byte, entry_index, byte_offset,
                list_done, last, output ready);
endinterface

>>> rtl/i2crbp_front.sv
// ----------------------------------------------------------------------------
// i2crbp_front
// Holds the configuration and the sequencing state, accepts bus events and
// turns those that call for commands into command bursts for the queue.
// ----------------------------------------------------------------------------
module i2crbp_front #(
  parameter int MAX_ENTRIES = i2crbp_pkg::MAX_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  i2crbp_event_if.sink        events,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [63:0]         wr_data,
  input  i2crbp_pkg::q_stat_t q_stat,
  output logic                push,
  output i2crbp_pkg::desc_t   desc
);

  localparam logic [2:0] PH_COLD    = 3'd0;
  localparam logic [2:0] PH_TXSEL   = 3'd1;
  localparam logic [2:0] PH_SENDREG = 3'd2;
  localparam logic [2:0] PH_RESTART = 3'd3;
  localparam logic [2:0] PH_RXSEL   = 3'd4;
  localparam logic [2:0] PH_READ    = 3'd5;
  localparam logic [2:0] PH_RELEASE = 3'd6;
  localparam logic [2:0] PH_HOT     = 3'd7;

  logic [6:0]  device_address;
  logic [3:0]  entry_count;
  logic [63:0] register_table;
  logic [63:0] length_table;

  logic [2:0] phase, phase_next;
  logic [2:0] current_entry, current_entry_next;
  logic [7:0] bytes_received, bytes_received_next;
  logic [7:0] bytes_requested, bytes_requested_next;

  logic       accept;
  logic [2:0] cur;
  logic [7:0] addr_byte;
  logic [7:0] len_byte;
  logic [7:0] len;
  logic [8:0] rec;
  logic [3:0] eff_count;
  logic [3:0] next_pos;

  assign events.ready = !q_stat.full;
  assign accept       = events.valid && events.ready;
  assign cur          = (phase == PH_COLD) ? 3'd0 : current_entry;
  assign addr_byte    = {device_address, 1'b0};
  assign len_byte     = length_table[{cur, 3'b000} +: 8];
  assign len          = (len_byte == 8'd0) ? 8'd1 : len_byte;
  assign rec          = {1'b0, bytes_received} + 9'd1;
  assign next_pos     = {1'b0, cur} + 4'd1;

  always_comb begin
    eff_count = (entry_count == 4'd0) ? 4'd1 : entry_count;
    if (eff_count > 4'(MAX_ENTRIES)) begin
      eff_count = 4'(MAX_ENTRIES);
    end
  end

  always_comb begin
    phase_next           = phase;
    current_entry_next   = cur;
    bytes_received_next  = bytes_received;
    bytes_requested_next = bytes_requested;
    desc                 = '0;
    desc.entry           = cur;
    case (phase)
      PH_COLD, PH_HOT: begin
        if (events.action == i2crbp_pkg::ACT_START_SENT) begin
          desc.cmd      = i2crbp_pkg::CMD_ADDR_W;
          desc.cmd_byte = addr_byte;
          desc.n        = 2'd1;
          phase_next    = PH_TXSEL;
        end
      end
      PH_TXSEL: begin
        if (events.action == i2crbp_pkg::ACT_TX_MODE) begin
          desc.cmd      = i2crbp_pkg::CMD_REG;
          desc.cmd_byte = register_table[{cur, 3'b000} +: 8];
          desc.n        = 2'd1;
          phase_next    = PH_SENDREG;
        end
      end
      PH_SENDREG: begin
        if (events.action == i2crbp_pkg::ACT_BYTE_SENT) begin
          desc.cmd   = i2crbp_pkg::CMD_START;
          desc.n     = 2'd1;
          phase_next = PH_RESTART;
        end
      end
      PH_RESTART: begin
        if (events.action == i2crbp_pkg::ACT_START_SENT) begin
          desc.cmd      = i2crbp_pkg::CMD_ADDR_R;
          desc.cmd_byte = addr_byte | 8'd1;
          desc.n        = 2'd1;
          phase_next    = PH_RXSEL;
        end
      end
      PH_RXSEL: begin
        if (events.action == i2crbp_pkg::ACT_RX_MODE) begin
          bytes_requested_next = len;
          bytes_received_next  = 8'd0;
          if (len == 8'd1) begin
            desc.cmd = i2crbp_pkg::CMD_ACK_OFF;
            desc.n   = 2'd2;
          end
          phase_next = PH_READ;
        end
      end
      PH_READ: begin
        if (events.action == i2crbp_pkg::ACT_BYTE_RCVD) begin
          desc.cmd            = i2crbp_pkg::CMD_STORE;
          desc.cmd_byte       = events.rx_data;
          desc.offset         = bytes_received;
          desc.n              = ({2'b00, bytes_requested} == {1'b0, rec} + 10'd1) ? 2'd3 : 2'd1;
          bytes_received_next = rec[7:0];
          if (rec >= {1'b0, bytes_requested}) begin
            phase_next = PH_RELEASE;
          end
        end
      end
      PH_RELEASE: begin
        if (events.action == i2crbp_pkg::ACT_RELEASED) begin
          desc.cmd = i2crbp_pkg::CMD_ACK_ON;
          if (next_pos >= eff_count) begin
            desc.done          = 1'b1;
            desc.n             = 2'd1;
            current_entry_next = 3'd0;
            phase_next         = PH_COLD;
          end else begin
            desc.n             = 2'd2;
            current_entry_next = cur + 3'd1;
            phase_next         = PH_HOT;
          end
        end
      end
      default: begin
      end
    endcase
    push = accept && (desc.n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_COLD;
      current_entry   <= 3'd0;
      bytes_received  <= 8'd0;
      bytes_requested <= 8'd0;
    end else if (accept) begin
      phase           <= phase_next;
      current_entry   <= current_entry_next;
      bytes_received  <= bytes_received_next;
      bytes_requested <= bytes_requested_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2crbp_pkg::DEVICE_ADDRESS_RST;
      entry_count    <= i2crbp_pkg::ENTRY_COUNT_RST;
      register_table <= i2crbp_pkg::REGISTER_TABLE_RST;
      length_table   <= i2crbp_pkg::LENGTH_TABLE_RST;
    end else if (wr_en) begin
      case (wr_index)
        i2crbp_pkg::REG_DEVICE_ADDRESS: device_address <= wr_data[6:0];
        i2crbp_pkg::REG_ENTRY_COUNT:    entry_count    <= wr_data[3:0];
        i2crbp_pkg::REG_REGISTER_TABLE: register_table <= wr_data;
        i2crbp_pkg::REG_LENGTH_TABLE:   length_table   <= wr_data;
        default: begin
        end
      endcase
    end
  end

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (desc.n != 2'd0) && !q_stat.full)
    else $error("front pushed an empty burst or into a full queue");

  a_done_only_on_ack_on: assert property (@(posedge clk) disable iff (rst)
    (push && desc.done) |=> (phase == PH_COLD) && (current_entry == 3'd0))
    else $error("list end did not return to cold start");

endmodule

>>> rtl/i2crbp_queue.sv
// ----------------------------------------------------------------------------
// i2crbp_queue
// Short FIFO of command bursts between the front and the back.
// ----------------------------------------------------------------------------
module i2crbp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  i2crbp_pkg::desc_t   push_desc,
  input  logic                pop,
  output i2crbp_pkg::desc_t   head,
  output i2crbp_pkg::q_stat_t q_stat
);

  localparam int PTR_W = (i2crbp_pkg::QDEPTH > 1) ? $clog2(i2crbp_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(i2crbp_pkg::QDEPTH + 1);

  i2crbp_pkg::desc_t slots [i2crbp_pkg::QDEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(i2crbp_pkg::QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head         = slots[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == CNT_W'(i2crbp_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue underflow");

endmodule

>>> rtl/i2crbp_back.sv
// ----------------------------------------------------------------------------
// i2crbp_back
// Expands each queued burst into its commands, one per cycle while the output
// is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module i2crbp_back (
  input  logic                clk,
  input  logic                rst,
  input  i2crbp_pkg::desc_t   head,
  input  i2crbp_pkg::q_stat_t q_stat,
  output logic                pop,
  i2crbp_result_if.source     results
);

  logic [1:0] idx;
  logic       load;
  logic       emit;
  logic       final_cmd;
  logic [2:0] cmd;
  logic [7:0] cmd_byte;
  logic [2:0] entry;
  logic [7:0] offset;
  logic       done;

  assign load      = !results.valid || results.ready;
  assign emit      = load && !q_stat.empty;
  assign final_cmd = (idx + 2'd1 == head.n);
  assign pop       = emit && final_cmd;

  always_comb begin
    cmd      = head.cmd;
    cmd_byte = 8'd0;
    entry    = head.entry;
    offset   = 8'd0;
    done     = 1'b0;
    case (idx)
      2'd0: begin
        cmd_byte = head.cmd_byte;
        offset   = head.offset;
        done     = head.done;
      end
      2'd1: begin
        case (head.cmd)
          i2crbp_pkg::CMD_STORE:   cmd = i2crbp_pkg::CMD_ACK_OFF;
          i2crbp_pkg::CMD_ACK_OFF: cmd = i2crbp_pkg::CMD_STOP;
          default: begin
            cmd   = i2crbp_pkg::CMD_START;
            entry = head.entry + 3'd1;
          end
        endcase
      end
      default: begin
        cmd = i2crbp_pkg::CMD_STOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
      idx           <= 2'd0;
    end else if (load) begin
      results.valid <= !q_stat.empty;
      if (emit) begin
        idx <= final_cmd ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      results.command      <= cmd;
      results.command_byte <= cmd_byte;
      results.entry_index  <= entry;
      results.byte_offset  <= offset;
      results.list_done    <= done;
      results.last         <= final_cmd;
    end
  end

  a_idx_in_burst: assert property (@(posedge clk) disable iff (rst)
    !q_stat.empty |-> (idx < head.n))
    else $error("command index beyond its burst");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.list_done) |->
      (results.last && results.command == i2crbp_pkg::CMD_ACK_ON))
    else $error("list end flag on a wrong command");

endmodule

>>> rtl/i2c_register_block_poller_unit.sv
// ----------------------------------------------------------------------------
// i2c_register_block_poller_unit
// I2C master sequencer that reads a list of register blocks from one device
// and reports each bus command and received byte.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake      Payload
// events    in   valid/ready    action, rx_data
// results   out  valid/ready    command, command_byte, entry_index,
//                               byte_offset, list_done, last
// wr_*      in   wr_en strobe   wr_index, wr_data
//
// A request yields zero to three commands, which leave one per cycle from the
// output register while the output is not stalled, through the command
// expander behind the two-entry queue. Reset is synchronous and returns the
// list to cold start with reset values in all configuration registers. A
// stalled output fills the queue, then holds requests off.
// ----------------------------------------------------------------------------
module i2c_register_block_poller_unit #(
  parameter int MAX_ENTRIES = i2crbp_pkg::MAX_ENTRIES
) (
  input  logic            clk,
  input  logic            rst,
  i2crbp_event_if.sink    events,
  i2crbp_result_if.source results,
  input  logic            wr_en,
  input  logic [1:0]      wr_index,
  input  logic [63:0]     wr_data
);

  i2crbp_pkg::desc_t   push_desc;
  i2crbp_pkg::desc_t   head;
  i2crbp_pkg::q_stat_t q_stat;
  logic                push;
  logic                pop;

  i2crbp_front #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .events  (events),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .q_stat  (q_stat),
    .push    (push),
    .desc    (push_desc)
  );

  i2crbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_desc(push_desc),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  i2crbp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .results(results)
  );

endmodule
